/* hdl/dlr_pkg.sv */
// shared types and constants for the delay rescale block
`timescale 1ns / 1ps
`default_nettype none
package dlr_pkg;

	localparam int DELAY_WIDTH_DEF = 8;
	localparam int CLOCK_WIDTH_DEF = 10;
	localparam int WORD_W          = 32;
	localparam int MEAS_W          = 8;
	localparam int CFG_IDX_W       = 1;
	localparam int CLOCK_RESET     = 200;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CURRENT_CLOCK = 1'b0,
		REG_TARGET_CLOCK  = 1'b1
	} cfg_reg_t;

	// lane kinds
	typedef enum logic {
		FUNC_ADDR_CMD = 1'b0,
		FUNC_DATA     = 1'b1
	} lane_func_t;

	// request words carried alongside the period divider
	typedef struct packed {
		logic              func;
		logic [WORD_W-1:0] master;
		logic [WORD_W-1:0] w0;
		logic [WORD_W-1:0] w1;
		logic [WORD_W-1:0] w2;
	} side_a_t;

	// request words carried alongside the delay dividers
	typedef struct packed {
		logic              func;
		logic              err;
		logic [WORD_W-1:0] master;
		logic [WORD_W-1:0] w0;
		logic [WORD_W-1:0] w2;
	} side_b_t;

endpackage
`default_nettype wire

/* hdl/dlr_if.sv */
// channel interfaces for lane requests, results and configuration writes
`timescale 1ns / 1ps
`default_nettype none
interface dlr_lane_in_if import dlr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              func;
	logic [MEAS_W-1:0] measured_period;
	logic [WORD_W-1:0] trained_master_word;
	logic [WORD_W-1:0] trained_delay_word0;
	logic [WORD_W-1:0] trained_delay_word1;
	logic [WORD_W-1:0] trained_delay_word2;
	modport source (output valid, func, measured_period, trained_master_word,
		trained_delay_word0, trained_delay_word1, trained_delay_word2, input ready);
	modport sink (input valid, func, measured_period, trained_master_word,
		trained_delay_word0, trained_delay_word1, trained_delay_word2, output ready);
endinterface

interface dlr_lane_out_if import dlr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] new_master_word;
	logic [WORD_W-1:0] new_delay_word0;
	logic [WORD_W-1:0] new_delay_word1;
	logic [WORD_W-1:0] new_delay_word2;
	logic              period_error;
	modport source (output valid, new_master_word, new_delay_word0, new_delay_word1,
		new_delay_word2, period_error, input ready);
	modport sink (input valid, new_master_word, new_delay_word0, new_delay_word1,
		new_delay_word2, period_error, output ready);
endinterface

interface dlr_cfg_if import dlr_pkg::*; #(parameter int DATA_W = CLOCK_WIDTH_DEF) ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hdl/dlr_div_cell.sv */
// one restoring division step per lane, registered, with handshake to the next cell
`timescale 1ns / 1ps
`default_nettype none
module dlr_div_cell #(
	parameter int LANES  = 1,
	parameter int NUM_W  = 18,
	parameter int DIV_W  = 10,
	parameter int SIDE_W = 1
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             up_valid,
	output logic                                  up_ready,
	input  wire logic [LANES-1:0][NUM_W-1:0]      up_num,
	input  wire logic [LANES-1:0][DIV_W-1:0]      up_rem,
	input  wire logic [DIV_W-1:0]                 up_div,
	input  wire logic [SIDE_W-1:0]                up_side,
	output logic                                  dn_valid,
	input  wire logic                             dn_ready,
	output logic [LANES-1:0][NUM_W-1:0]           dn_num,
	output logic [LANES-1:0][DIV_W-1:0]           dn_rem,
	output logic [DIV_W-1:0]                      dn_div,
	output logic [SIDE_W-1:0]                     dn_side
);

	logic                        valid_q;
	logic [LANES-1:0][NUM_W-1:0] num_q;
	logic [LANES-1:0][DIV_W-1:0] rem_q;
	logic [DIV_W-1:0]            div_q;
	logic [SIDE_W-1:0]           side_q;
	logic [LANES-1:0][NUM_W-1:0] num_d;
	logic [LANES-1:0][DIV_W-1:0] rem_d;
	logic                        en;

	// stage advances when empty or when the next cell takes its contents
	assign en       = !valid_q || dn_ready;
	assign up_ready = en;

	// shift one numerator bit into the remainder, subtract when it fits
	always_comb begin
		logic [DIV_W:0] trial;
		logic [DIV_W:0] diff;
		for (int l = 0; l < LANES; l++) begin
			trial = {up_rem[l], up_num[l][NUM_W-1]};
			diff  = trial - {1'b0, up_div};
			if (trial >= {1'b0, up_div}) begin
				rem_d[l] = diff[DIV_W-1:0];
				num_d[l] = {up_num[l][NUM_W-2:0], 1'b1};
			end else begin
				rem_d[l] = trial[DIV_W-1:0];
				num_d[l] = {up_num[l][NUM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && up_valid) begin
			num_q  <= num_d;
			rem_q  <= rem_d;
			div_q  <= up_div;
			side_q <= up_side;
		end
	end

	assign dn_valid = valid_q;
	assign dn_num   = num_q;
	assign dn_rem   = rem_q;
	assign dn_div   = div_q;
	assign dn_side  = side_q;

endmodule
`default_nettype wire

/* hdl/dlr_div_chain.sv */
// row of division cells, one quotient bit per cell, lanes share the divisor
`timescale 1ns / 1ps
`default_nettype none
module dlr_div_chain #(
	parameter int LANES  = 1,
	parameter int NUM_W  = 18,
	parameter int DIV_W  = 10,
	parameter int SIDE_W = 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [LANES-1:0][NUM_W-1:0] in_num,
	input  wire logic [DIV_W-1:0]            in_div,
	input  wire logic [SIDE_W-1:0]           in_side,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [LANES-1:0][NUM_W-1:0]      out_quo,
	output logic [SIDE_W-1:0]                out_side
);

	logic                        v   [NUM_W+1];
	logic                        rdy [NUM_W+1];
	logic [LANES-1:0][NUM_W-1:0] num [NUM_W+1];
	logic [LANES-1:0][DIV_W-1:0] rem [NUM_W+1];
	logic [DIV_W-1:0]            dv  [NUM_W+1];
	logic [SIDE_W-1:0]           sd  [NUM_W+1];

	// chain head: remainder starts at zero
	assign v[0]     = in_valid;
	assign in_ready = rdy[0];
	assign num[0]   = in_num;
	assign rem[0]   = '0;
	assign dv[0]    = in_div;
	assign sd[0]    = in_side;

	for (genvar i = 0; i < NUM_W; i++) begin : g_cell
		dlr_div_cell #(
			.LANES (LANES),
			.NUM_W (NUM_W),
			.DIV_W (DIV_W),
			.SIDE_W(SIDE_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_valid(v[i]),
			.up_ready(rdy[i]),
			.up_num  (num[i]),
			.up_rem  (rem[i]),
			.up_div  (dv[i]),
			.up_side (sd[i]),
			.dn_valid(v[i+1]),
			.dn_ready(rdy[i+1]),
			.dn_num  (num[i+1]),
			.dn_rem  (rem[i+1]),
			.dn_div  (dv[i+1]),
			.dn_side (sd[i+1])
		);
	end

	// chain tail: numerator register now holds the quotient
	assign rdy[NUM_W] = out_ready;
	assign out_valid  = v[NUM_W];
	assign out_quo    = num[NUM_W];
	assign out_side   = sd[NUM_W];

endmodule
`default_nettype wire

/* hdl/ddr_phy_delay_rescale_top.sv */
// top level of the delay rescale block: config registers, multiply stages, divider chains
`timescale 1ns / 1ps
`default_nettype none
// Rescales one PHY lane per request for a memory clock change. The measured period
// is scaled by current/target clock, placed in bits of the master word's second
// field, and trained delay fields are scaled by new/trained period: all seven on a
// data lane, only the first on an address/command lane (words one and two cleared).
// One request is taken per cycle unless the output stalls; results pass stage 1, the
// period chain, stage 2, the delay chain and stage 3, one quotient bit per divider
// cell. Results stall in place and bubbles in the chains still accept new requests
// while an output waits. A zero trained period raises period_error, clearing delay words.
module ddr_phy_delay_rescale_top import dlr_pkg::*; #(
	parameter int DELAY_WIDTH = DELAY_WIDTH_DEF,
	parameter int CLOCK_WIDTH = CLOCK_WIDTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	dlr_lane_in_if.sink     lane_in,
	dlr_lane_out_if.source  lane_out,
	dlr_cfg_if.sink         cfg
);

	localparam int DW     = DELAY_WIDTH;
	localparam int CW     = CLOCK_WIDTH;
	localparam int NA_W   = MEAS_W + CLOCK_WIDTH;
	localparam int NB_W   = 2 * DELAY_WIDTH;
	localparam int LANES  = 7;
	localparam int SA_W   = $bits(side_a_t);
	localparam int SB_W   = $bits(side_b_t);
	localparam logic [63:0]       DMASK64   = (64'd1 << DELAY_WIDTH) - 64'd1;
	localparam logic [MEAS_W-1:0] MEAS_MASK = MEAS_W'(DMASK64);

	function automatic logic [DW-1:0] fget(input logic [WORD_W-1:0] w, input int idx);
		logic [63:0] x;
		x = 64'(w) >> (idx * DELAY_WIDTH);
		return x[DW-1:0];
	endfunction

	function automatic logic [63:0] fput(input logic [DW-1:0] q, input int idx);
		return 64'(q) << (idx * DELAY_WIDTH);
	endfunction

	function automatic logic [63:0] low_fields(input int n);
		return (64'd1 << (n * DELAY_WIDTH)) - 64'd1;
	endfunction

	// configuration registers
	logic [CW-1:0] cur_clk_q;
	logic [CW-1:0] tgt_clk_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_clk_q <= CW'(CLOCK_RESET);
			tgt_clk_q <= CW'(CLOCK_RESET);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CURRENT_CLOCK: cur_clk_q <= CW'(cfg.data);
				REG_TARGET_CLOCK:  tgt_clk_q <= CW'(cfg.data);
				default:           cur_clk_q <= cur_clk_q;
			endcase
		end
	end

	// stage 1: measured period times current clock
	logic                       v_s1;
	logic [0:0][NA_W-1:0]       num_s1;
	logic [CW-1:0]              div_s1;
	side_a_t                    side_s1;
	logic                       en_s1;
	logic                       a_in_ready;

	assign en_s1         = !v_s1 || a_in_ready;
	assign lane_in.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= lane_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && lane_in.valid) begin
			num_s1[0]      <= NA_W'(lane_in.measured_period & MEAS_MASK) * NA_W'(cur_clk_q);
			div_s1         <= tgt_clk_q;
			side_s1.func   <= lane_in.func;
			side_s1.master <= lane_in.trained_master_word;
			side_s1.w0     <= lane_in.trained_delay_word0;
			side_s1.w1     <= lane_in.trained_delay_word1;
			side_s1.w2     <= lane_in.trained_delay_word2;
		end
	end

	// period divider chain
	logic                 a_out_valid;
	logic                 a_out_ready;
	logic [0:0][NA_W-1:0] a_quo;
	logic [SA_W-1:0]      a_side_raw;
	side_a_t              a_side;

	dlr_div_chain #(
		.LANES (1),
		.NUM_W (NA_W),
		.DIV_W (CW),
		.SIDE_W(SA_W)
	) u_prd_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.in_ready (a_in_ready),
		.in_num   (num_s1),
		.in_div   (div_s1),
		.in_side  (side_s1),
		.out_valid(a_out_valid),
		.out_ready(a_out_ready),
		.out_quo  (a_quo),
		.out_side (a_side_raw)
	);

	assign a_side = side_a_t'(a_side_raw);

	// stage 2: new master word, trained fields times new period
	logic [DW-1:0]               new_prd;
	logic [DW-1:0]               old_prd;
	logic [LANES-1:0][DW-1:0]    fld;
	logic [WORD_W-1:0]           nm_word;
	logic                        v_s2;
	logic [LANES-1:0][NB_W-1:0]  num_s2;
	logic [DW-1:0]               div_s2;
	side_b_t                     side_s2;
	logic                        en_s2;
	logic                        b_in_ready;

	always_comb begin
		new_prd = a_quo[0][DW-1:0];
		old_prd = fget(a_side.master, 1);
		nm_word = WORD_W'((64'(a_side.master) & ~(DMASK64 << DELAY_WIDTH))
			| fput(new_prd, 1));
		fld[0]  = fget(a_side.w0, 0);
		fld[1]  = fget(a_side.w0, 1);
		fld[2]  = fget(a_side.w1, 0);
		fld[3]  = fget(a_side.w1, 1);
		fld[4]  = fget(a_side.w1, 2);
		fld[5]  = fget(a_side.w2, 0);
		fld[6]  = fget(a_side.w2, 1);
	end

	assign en_s2       = !v_s2 || b_in_ready;
	assign a_out_ready = en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= a_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && a_out_valid) begin
			for (int l = 0; l < LANES; l++) begin
				num_s2[l] <= NB_W'(fld[l]) * NB_W'(new_prd);
			end
			div_s2         <= old_prd;
			side_s2.func   <= a_side.func;
			side_s2.err    <= (old_prd == '0);
			side_s2.master <= nm_word;
			side_s2.w0     <= a_side.w0;
			side_s2.w2     <= a_side.w2;
		end
	end

	// delay field divider chain, seven lanes
	logic                       b_out_valid;
	logic                       b_out_ready;
	logic [LANES-1:0][NB_W-1:0] b_quo;
	logic [SB_W-1:0]            b_side_raw;
	side_b_t                    b_side;

	dlr_div_chain #(
		.LANES (LANES),
		.NUM_W (NB_W),
		.DIV_W (DW),
		.SIDE_W(SB_W)
	) u_dly_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s2),
		.in_ready (b_in_ready),
		.in_num   (num_s2),
		.in_div   (div_s2),
		.in_side  (side_s2),
		.out_valid(b_out_valid),
		.out_ready(b_out_ready),
		.out_quo  (b_quo),
		.out_side (b_side_raw)
	);

	assign b_side = side_b_t'(b_side_raw);

	// stage 3: assemble result words
	logic [WORD_W-1:0] w0_d;
	logic [WORD_W-1:0] w1_d;
	logic [WORD_W-1:0] w2_d;
	logic              v_s3;
	logic              en_s3;
	logic [WORD_W-1:0] nm_s3;
	logic [WORD_W-1:0] w0_s3;
	logic [WORD_W-1:0] w1_s3;
	logic [WORD_W-1:0] w2_s3;
	logic              err_s3;

	always_comb begin
		logic [63:0] x0;
		logic [63:0] x1;
		logic [63:0] x2;
		if (b_side.func == FUNC_DATA) begin
			x0 = (64'(b_side.w0) & ~low_fields(2)) | fput(b_quo[0][DW-1:0], 0)
				| fput(b_quo[1][DW-1:0], 1);
			x1 = fput(b_quo[2][DW-1:0], 0) | fput(b_quo[3][DW-1:0], 1)
				| fput(b_quo[4][DW-1:0], 2);
			x2 = (64'(b_side.w2) & ~low_fields(2)) | fput(b_quo[5][DW-1:0], 0)
				| fput(b_quo[6][DW-1:0], 1);
		end else begin
			x0 = (64'(b_side.w0) & ~low_fields(1)) | fput(b_quo[0][DW-1:0], 0);
			x1 = '0;
			x2 = '0;
		end
		if (b_side.err) begin
			x0 = '0;
			x1 = '0;
			x2 = '0;
		end
		w0_d = x0[WORD_W-1:0];
		w1_d = x1[WORD_W-1:0];
		w2_d = x2[WORD_W-1:0];
	end

	assign en_s3       = !v_s3 || lane_out.ready;
	assign b_out_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= b_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && b_out_valid) begin
			nm_s3  <= b_side.master;
			w0_s3  <= w0_d;
			w1_s3  <= w1_d;
			w2_s3  <= w2_d;
			err_s3 <= b_side.err;
		end
	end

	assign lane_out.valid           = v_s3;
	assign lane_out.new_master_word = nm_s3;
	assign lane_out.new_delay_word0 = w0_s3;
	assign lane_out.new_delay_word1 = w1_s3;
	assign lane_out.new_delay_word2 = w2_s3;
	assign lane_out.period_error    = err_s3;

endmodule
`default_nettype wire

/* hdl/dlr_checker.sv */
// port-level checks on the delay rescale top level, bound to it
`timescale 1ns / 1ps
`default_nettype none
module dlr_checker import dlr_pkg::*; #(
	parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [WORD_W-1:0] new_master_word,
	input wire logic [WORD_W-1:0] new_delay_word0,
	input wire logic [WORD_W-1:0] new_delay_word1,
	input wire logic [WORD_W-1:0] new_delay_word2,
	input wire logic              period_error
);

	localparam logic [63:0]       W1_MASK64 = (64'd1 << (3 * DELAY_WIDTH)) - 64'd1;
	localparam logic [WORD_W-1:0] W1_MASK   = WORD_W'(W1_MASK64);

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its master word and first delay word
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(new_master_word) && $stable(new_delay_word0))
		else $error("result changed while stalled");

	// period error clears every delay word
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && period_error |-> new_delay_word0 == '0 && new_delay_word1 == '0
			&& new_delay_word2 == '0)
		else $error("delay words not cleared on period error");

	// second delay word has nothing above its three fields
	a_w1_upper: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (new_delay_word1 & ~W1_MASK) == '0)
		else $error("upper bits of second delay word not cleared");

endmodule

bind ddr_phy_delay_rescale_top dlr_checker #(.DELAY_WIDTH(DELAY_WIDTH)) u_dlr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (lane_out.valid),
	.out_ready      (lane_out.ready),
	.new_master_word(lane_out.new_master_word),
	.new_delay_word0(lane_out.new_delay_word0),
	.new_delay_word1(lane_out.new_delay_word1),
	.new_delay_word2(lane_out.new_delay_word2),
	.period_error   (lane_out.period_error)
);
`default_nettype wire
